// ----- hw/rtl/cosine_antenna_gain_defines.svh -----
// assertion macros for the cosine antenna gain port checker
`ifndef COSINE_ANTENNA_GAIN_DEFINES_SVH
`define COSINE_ANTENNA_GAIN_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CAG_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define CAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also checks the cycle after reset
`define CAG_ASSERT_RST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cag_pkg.sv -----
// types, constants and table-building functions for the cosine antenna gain block
package cag_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int ATTEN_W    = 16;
  localparam int TERM_W     = 24;
  localparam int SUM_W      = 27;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;
  localparam int REG_IW     = 2;

  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = 16'h4000;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN    = 16'h8000;

  localparam logic signed [15:0] GAIN_MIN = 16'sh8000;
  localparam logic signed [15:0] GAIN_MAX = 16'sh7FFF;

  // register indexes
  localparam logic [REG_IW-1:0] REG_ORIENT = 2'd0;
  localparam logic [REG_IW-1:0] REG_HEXP   = 2'd1;
  localparam logic [REG_IW-1:0] REG_VEXP   = 2'd2;
  localparam logic [REG_IW-1:0] REG_MAXG   = 2'd3;

  localparam logic [15:0] HEXP_RST = 16'd2549;

  // table construction constants
  localparam logic [63:0] ONE_Q30        = 64'd1 << 30;
  localparam logic [63:0] PI_Q30         = 64'd3373259426;
  localparam logic [63:0] DB_PER_OCT_Q16 = 64'd394566;

  typedef struct packed {
    logic signed [15:0] azimuth_angle;
    logic [15:0]        inclination_angle;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] gain_db;
    logic               floor_hit;
  } out_word_t;

  // fold a binary angle to its magnitude in [0, half turn]
  function automatic logic [ANGLE_BITS-1:0] fold_angle(input logic [ANGLE_BITS-1:0] u);
    return (u > HALF_TURN) ? (~u + 16'd1) : u;
  endfunction

  // taylor denominators (2k-1)*(2k)
  function automatic logic [63:0] taylor_div(input logic [63:0] x, input int k);
    case (k)
      1:       return x / 64'd2;
      2:       return x / 64'd12;
      3:       return x / 64'd30;
      4:       return x / 64'd56;
      5:       return x / 64'd90;
      6:       return x / 64'd132;
      7:       return x / 64'd182;
      8:       return x / 64'd240;
      9:       return x / 64'd306;
      10:      return x / 64'd380;
      11:      return x / 64'd462;
      default: return x / 64'd552;
    endcase
  endfunction

  // cosine in q30 by truncating series, clamped to [1, 1.0]
  function automatic logic [63:0] cos_q30(input logic [63:0] t);
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    t2   = (t * t) >> 30;
    term = ONE_Q30;
    sum  = $signed(ONE_Q30);
    for (int k = 1; k <= 12; k++) begin
      term = taylor_div((term * t2) >> 30, k);
      if ((k & 1) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 64'sd1) begin
      sum = 64'sd1;
    end
    if (sum > $signed(ONE_Q30)) begin
      sum = $signed(ONE_Q30);
    end
    return $unsigned(sum);
  endfunction

  // -20*log10(c) in q8.8 dB via log2 by repeated squaring
  function automatic logic [ATTEN_W-1:0] atten_of(input logic [63:0] c);
    logic [63:0] cc;
    logic [63:0] n;
    logic [63:0] frac;
    logic [63:0] mag;
    logic [63:0] scaled;
    cc   = c;
    n    = 64'd0;
    frac = 64'd0;
    for (int j = 0; j < 32; j++) begin
      if (cc < ONE_Q30) begin
        cc = cc << 1;
        n  = n + 64'd1;
      end
    end
    for (int b = 19; b >= 0; b--) begin
      cc = (cc * cc) >> 30;
      if (cc >= (ONE_Q30 << 1)) begin
        cc   = cc >> 1;
        frac = frac | (64'd1 << b);
      end
    end
    mag    = (n << 20) - frac;
    scaled = (mag * DB_PER_OCT_Q16 + (64'd1 << 27)) >> 28;
    return scaled[ATTEN_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/cag_atten_rom.sv -----
// dual-read attenuation rom with registered read data
module cag_atten_rom #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   addr_h,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   addr_v,
  output logic [cag_pkg::ATTEN_W-1:0]      data_h,
  output logic [cag_pkg::ATTEN_W-1:0]      data_v
);

  logic [cag_pkg::ATTEN_W-1:0] rom_tbl [TABLE_DEPTH];
  logic [cag_pkg::ATTEN_W-1:0] data_h_r;
  logic [cag_pkg::ATTEN_W-1:0] data_v_r;

  // entry i holds the attenuation at i/TABLE_DEPTH of a half turn, halved
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] ANG =
      (64'(g) * cag_pkg::PI_Q30) / (64'd2 * 64'(TABLE_DEPTH));
    assign rom_tbl[g] = cag_pkg::atten_of(cag_pkg::cos_q30(ANG));
  end

  // two read ports, held while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_h_r <= rom_tbl[addr_h];
      data_v_r <= rom_tbl[addr_v];
    end
  end

  assign data_h = data_h_r;
  assign data_v = data_v_r;

endmodule

// ----- hw/rtl/cosine_antenna_gain.sv -----
// top level of the cosine antenna element gain block
// Gain of a cosine-pattern antenna element: one angle pair in, one Q8.8 dB gain out, one word
// per clock sustained; the whole pipeline freezes while out_stall holds a valid result. A word
// runs through five register stages (angle fold, table index, attenuation rom read, exponent
// multiply, sum and saturate) before it shows on out_word. The rom holds TABLE_DEPTH entries
// and is read at two addresses, one for the horizontal and one for the vertical term, whenever
// the pipeline advances. A one-word skid buffer at the input keeps in_stall a register: it rises
// only after the output has been held off. Registers sit at byte addresses 0, 4, 8 and 12 and
// are meant to be written only while no word is in flight.
module cosine_antenna_gain #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cag_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cag_pkg::out_word_t            out_word,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [cag_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [cag_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [cag_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = cag_pkg::ANGLE_BITS - 1 + IW;
  localparam logic [IW-1:0] DEPTH_IDX = IW'(TABLE_DEPTH);

  // configuration registers
  logic signed [15:0] orient_r;
  logic [15:0]        hexp_r;
  logic [15:0]        vexp_r;
  logic signed [15:0] maxg_r;

  logic                       cfg_wr;
  logic [cag_pkg::REG_IW-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[cag_pkg::CFG_AW-1 -: cag_pkg::REG_IW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r <= '0;
      hexp_r   <= cag_pkg::HEXP_RST;
      vexp_r   <= '0;
      maxg_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cag_pkg::REG_ORIENT: orient_r <= cfg_pwdata[15:0];
        cag_pkg::REG_HEXP:   hexp_r   <= cfg_pwdata[15:0];
        cag_pkg::REG_VEXP:   vexp_r   <= cfg_pwdata[15:0];
        cag_pkg::REG_MAXG:   maxg_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    case (cfg_idx)
      cag_pkg::REG_ORIENT: cfg_prdata = cag_pkg::CFG_DW'($unsigned(orient_r));
      cag_pkg::REG_HEXP:   cfg_prdata = cag_pkg::CFG_DW'(hexp_r);
      cag_pkg::REG_VEXP:   cfg_prdata = cag_pkg::CFG_DW'(vexp_r);
      cag_pkg::REG_MAXG:   cfg_prdata = cag_pkg::CFG_DW'($unsigned(maxg_r));
      default:             cfg_prdata = '0;
    endcase
  end

  // pipeline advance and input skid buffer
  logic               adv;
  logic               in_acc;
  logic               skid_vld_r;
  logic               skid_vld_nxt;
  cag_pkg::in_word_t  skid_word_r;
  logic               src_vld;
  cag_pkg::in_word_t  src_word;
  logic               out_valid_r;
  cag_pkg::out_word_t out_word_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = skid_vld_r;
  assign in_acc   = in_valid && !skid_vld_r;
  assign src_vld  = skid_vld_r || in_acc;
  assign src_word = skid_vld_r ? skid_word_r : in_word;

  always_comb begin
    if (adv) begin
      skid_vld_nxt = 1'b0;
    end else if (in_acc) begin
      skid_vld_nxt = 1'b1;
    end else begin
      skid_vld_nxt = skid_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_acc) begin
      skid_word_r <= in_word;
    end
  end

  // stage 1: offset and fold both angles
  logic [15:0] dphi_raw;
  logic [15:0] dth_raw;
  logic        s1_vld_r;
  logic [15:0] s1_dphi_r;
  logic [15:0] s1_dth_r;

  assign dphi_raw = $unsigned(src_word.azimuth_angle) - $unsigned(orient_r);
  assign dth_raw  = src_word.inclination_angle - cag_pkg::QUARTER_TURN;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dphi_r <= cag_pkg::fold_angle(dphi_raw);
      s1_dth_r  <= cag_pkg::fold_angle(dth_raw);
    end
  end

  // stage 2: scale magnitude to a table index, flag the null
  logic [PW-1:0] prod_h;
  logic [PW-1:0] prod_v;
  logic [IW-1:0] idx_h;
  logic [IW-1:0] idx_v;
  logic          null_h;
  logic          null_v;
  logic          s2_vld_r;
  logic [AW-1:0] s2_addr_h_r;
  logic [AW-1:0] s2_addr_v_r;
  logic          s2_null_h_r;
  logic          s2_null_v_r;

  assign prod_h = PW'(s1_dphi_r) * PW'(TABLE_DEPTH);
  assign prod_v = PW'(s1_dth_r) * PW'(TABLE_DEPTH);
  assign idx_h  = prod_h[cag_pkg::ANGLE_BITS-1 +: IW];
  assign idx_v  = prod_v[cag_pkg::ANGLE_BITS-1 +: IW];
  assign null_h = idx_h >= DEPTH_IDX;
  assign null_v = idx_v >= DEPTH_IDX;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_addr_h_r <= null_h ? '0 : idx_h[AW-1:0];
      s2_addr_v_r <= null_v ? '0 : idx_v[AW-1:0];
      s2_null_h_r <= null_h;
      s2_null_v_r <= null_v;
    end
  end

  // stage 3: rom read; a null only counts where its exponent is non-zero
  logic [cag_pkg::ATTEN_W-1:0] rom_h;
  logic [cag_pkg::ATTEN_W-1:0] rom_v;
  logic                        s3_vld_r;
  logic                        s3_null_r;

  cag_atten_rom #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_cag_atten_rom (
    .clk    (clk),
    .rd_en  (adv),
    .addr_h (s2_addr_h_r),
    .addr_v (s2_addr_v_r),
    .data_h (rom_h),
    .data_v (rom_v)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_null_r <= (s2_null_h_r && (hexp_r != 16'd0)) || (s2_null_v_r && (vexp_r != 16'd0));
    end
  end

  // stage 4: exponent times attenuation, rounded to q8.8
  logic [31:0]                term_h;
  logic [31:0]                term_v;
  logic                       s4_vld_r;
  logic                       s4_null_r;
  logic [cag_pkg::TERM_W-1:0] s4_th_r;
  logic [cag_pkg::TERM_W-1:0] s4_tv_r;

  assign term_h = 32'(hexp_r) * 32'(rom_h) + 32'd128;
  assign term_v = 32'(vexp_r) * 32'(rom_v) + 32'd128;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_null_r <= s3_null_r;
      s4_th_r   <= term_h[31:8];
      s4_tv_r   <= term_v[31:8];
    end
  end

  // stage 5: sum and saturate
  logic signed [cag_pkg::SUM_W-1:0] total;
  cag_pkg::out_word_t               res_word;

  assign total = cag_pkg::SUM_W'(maxg_r)
               - $signed(cag_pkg::SUM_W'(s4_th_r))
               - $signed(cag_pkg::SUM_W'(s4_tv_r));

  always_comb begin
    if (s4_null_r || (total < cag_pkg::SUM_W'(cag_pkg::GAIN_MIN))) begin
      res_word.gain_db   = cag_pkg::GAIN_MIN;
      res_word.floor_hit = 1'b1;
    end else if (total > cag_pkg::SUM_W'(cag_pkg::GAIN_MAX)) begin
      res_word.gain_db   = cag_pkg::GAIN_MAX;
      res_word.floor_hit = 1'b0;
    end else begin
      res_word.gain_db   = total[15:0];
      res_word.floor_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= res_word;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r  <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      skid_vld_r <= skid_vld_nxt;
      if (adv) begin
        s1_vld_r    <= src_vld;
        s2_vld_r    <= s1_vld_r;
        s3_vld_r    <= s2_vld_r;
        s4_vld_r    <= s3_vld_r;
        out_valid_r <= s4_vld_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- hw/rtl/cag_port_checker.sv -----
// port-level checker for the cosine antenna gain block, bound to the top level
`include "cosine_antenna_gain_defines.svh"

module cag_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cag_pkg::out_word_t out_word
);

  // a held result stays valid and unchanged
  `CAG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled result word changed or dropped")

  // floor flag only comes with the minimum gain
  `CAG_ASSERT(a_floor_min, out_valid && out_word.floor_hit, out_word.gain_db == cag_pkg::GAIN_MIN, "floor flag without minimum gain")

  // input is only held off after the output was held off
  `CAG_ASSERT(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall), "input stall without output backpressure")

  // reset leaves the input open
  `CAG_ASSERT_RST_NEXT(a_reset_open, !rst_n, !in_stall, "input stalled right after reset")

endmodule

bind cosine_antenna_gain cag_port_checker u_cag_port_checker (.*);
